// File: src/stma_pkg.sv
// Shared types, constants and a helper function for the tile multiply-accumulate block.
`timescale 1ns / 1ps
package stma_pkg;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_LOAD   = 2'd1,
        CMD_UPDATE = 2'd2,
        CMD_EMIT   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_EMIT_RD,
        ST_EMIT_A,
        ST_EMIT_B,
        ST_HOLD
    } state_t;

    localparam logic REG_ALPHA = 1'b0;
    localparam logic REG_BETA  = 1'b1;

    localparam int FMA_LAT = 5;
    localparam int LAT_W   = $clog2(FMA_LAT + 1);

    localparam logic [31:0] FP_QNAN     = 32'h7FC0_0000;
    localparam logic [30:0] FP_INF_MAG  = 31'h7F80_0000;
    localparam logic [31:0] FP_NEG_ZERO = 32'h8000_0000;
    localparam logic [31:0] FP_ONE      = 32'h3F80_0000;

    function automatic logic [6:0] lzc64(input logic [63:0] v);
        logic [6:0] n;
        logic       found;
        n     = 7'd64;
        found = 1'b0;
        for (int k = 63; k >= 0; k--) begin
            if (!found && v[k]) begin
                n     = 7'(63 - k);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

// File: src/sgemm_tile_multiply_accumulate.sv
// Top level of the fp32 outer-product tile with its accumulator memory and control.
//
//  Channel   Handshake             Contents
//  s_*       s_tvalid / s_tready   command words (clear, load, rank-1 update, emit)
//  m_*       m_tvalid / m_tready   result words, one for each emit command
//  cfg_*     cfg_we                alpha and beta registers, write only
//
// A rank-1 update sweeps one accumulator row per cycle through the row memory, which
// has one read port and one write port, and the five-stage FMA lanes, then drains the
// lanes. An emit scales the stored element by alpha and, when beta is nonzero, adds beta
// times old_c in a second step; both steps go through one shared FMA. Reset clears the
// row valid bits, so the accumulators read as zero with no clearing pass. Input is taken
// only while idle; a result word still waiting on m_tready stalls the next emit in its hold state.
`timescale 1ns / 1ps
module sgemm_tile_multiply_accumulate #(
    parameter int TILE = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,   // row_index, col_index, a_element, b_element, old_c
    input  logic [1:0]   s_tuser,   // command
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,   // c_element, out_row, out_col
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_wdata
);
    import stma_pkg::*;

    localparam int RW = $clog2(TILE);
    localparam int MW = TILE * 32;

    state_t              state_reg, state_next;
    logic [RW-1:0]       sweep_cnt_reg, sweep_cnt_next;
    logic [LAT_W-1:0]    lat_cnt_reg, lat_cnt_next;

    logic [31:0]         alpha_reg, beta_reg;
    logic [TILE-1:0]     row_valid_reg;
    logic [31:0]         a_vec_reg [TILE];
    logic [31:0]         b_vec_reg [TILE];
    logic [MW-1:0]       acc_mem [TILE];

    logic [MW-1:0]       rd_data_reg;
    logic                rd_vld_reg, rd_pend_reg;
    logic [RW-1:0]       rd_idx_reg;
    logic [FMA_LAT-1:0]  wr_vld_reg;
    logic [RW-1:0]       wr_idx_reg [FMA_LAT];

    logic [4:0]          em_row_reg, em_col_reg;
    logic [31:0]         em_oc_reg, hold_reg;
    logic                em_in_range_reg;
    logic                out_valid_reg;
    logic [47:0]         out_data_reg;

    cmd_t                cmd;
    logic [4:0]          row_in, col_in;
    logic [31:0]         a_in, b_in, oc_in;
    logic                in_acc, row_ok, col_ok, beta_nz;
    logic                sweep_issue, emit_issue, rd_en, hold_load, out_load, wr_en;
    logic [RW-1:0]       rd_addr;
    logic [31:0]         z_sel, em_a, em_b, em_c, em_res;
    logic [MW-1:0]       wr_data;
    logic [31:0]         lane_c   [TILE];
    logic [31:0]         lane_res [TILE];

    assign cmd     = cmd_t'(s_tuser);
    assign row_in  = s_tdata[4:0];
    assign col_in  = s_tdata[9:5];
    assign a_in    = s_tdata[41:10];
    assign b_in    = s_tdata[73:42];
    assign oc_in   = s_tdata[105:74];
    assign in_acc  = s_tvalid && s_tready;
    assign row_ok  = ({2'd0, row_in} < 7'(TILE));
    assign col_ok  = ({2'd0, col_in} < 7'(TILE));
    assign beta_nz = (beta_reg[30:0] != 31'd0);
    assign wr_en   = wr_vld_reg[FMA_LAT-1];

    always_comb
    begin
        state_next     = state_reg;
        sweep_cnt_next = sweep_cnt_reg;
        lat_cnt_next   = lat_cnt_reg + LAT_W'(1);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && cmd == CMD_UPDATE) begin
                    state_next     = ST_SWEEP;
                    sweep_cnt_next = '0;
                end else if (in_acc && cmd == CMD_EMIT) begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_SWEEP:
            begin
                sweep_cnt_next = sweep_cnt_reg + RW'(1);
                if (sweep_cnt_reg == RW'(TILE - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_pend_reg && wr_vld_reg == '0) begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT_RD:
            begin
                state_next   = ST_EMIT_A;
                lat_cnt_next = LAT_W'(1);
            end
            ST_EMIT_A:
            begin
                if (lat_cnt_reg == LAT_W'(FMA_LAT)) begin
                    state_next   = beta_nz ? ST_EMIT_B : ST_HOLD;
                    lat_cnt_next = '0;
                end
            end
            ST_EMIT_B:
            begin
                if (lat_cnt_reg == LAT_W'(FMA_LAT)) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready    = (state_reg == ST_IDLE);
        sweep_issue = (state_reg == ST_SWEEP);
        emit_issue  = (state_reg == ST_IDLE) && s_tvalid && cmd == CMD_EMIT;
        rd_en       = sweep_issue || emit_issue;
        rd_addr     = sweep_issue ? sweep_cnt_reg : RW'(row_in);
        hold_load   = (lat_cnt_reg == LAT_W'(FMA_LAT))
                      && (state_reg == ST_EMIT_A || state_reg == ST_EMIT_B);
        out_load    = (state_reg == ST_HOLD) && (!out_valid_reg || m_tready);
        z_sel       = (em_in_range_reg && rd_vld_reg)
                      ? rd_data_reg[32 * int'(RW'(em_col_reg)) +: 32] : 32'd0;
        em_a        = (state_reg == ST_EMIT_RD) ? alpha_reg : em_oc_reg;
        em_b        = (state_reg == ST_EMIT_RD) ? z_sel : beta_reg;
        em_c        = (state_reg == ST_EMIT_RD) ? FP_NEG_ZERO : hold_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            sweep_cnt_reg <= '0;
            lat_cnt_reg   <= '0;
            alpha_reg     <= FP_ONE;
            beta_reg      <= 32'd0;
            row_valid_reg <= '0;
            rd_pend_reg   <= 1'b0;
            wr_vld_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sweep_cnt_reg <= sweep_cnt_next;
            lat_cnt_reg   <= lat_cnt_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_ALPHA: alpha_reg <= cfg_wdata;
                    REG_BETA:  beta_reg  <= cfg_wdata;
                    default:   alpha_reg <= alpha_reg;
                endcase
            end
            if (in_acc && cmd == CMD_CLEAR) begin
                row_valid_reg <= '0;
            end else if (wr_en) begin
                row_valid_reg[wr_idx_reg[FMA_LAT-1]] <= 1'b1;
            end
            rd_pend_reg <= sweep_issue;
            wr_vld_reg  <= {wr_vld_reg[FMA_LAT-2:0], rd_pend_reg};
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && cmd == CMD_LOAD) begin
            if (row_ok) begin
                a_vec_reg[RW'(row_in)] <= a_in;
            end
            if (col_ok) begin
                b_vec_reg[RW'(col_in)] <= b_in;
            end
        end
        if (in_acc && cmd == CMD_EMIT) begin
            em_row_reg      <= row_in;
            em_col_reg      <= col_in;
            em_oc_reg       <= oc_in;
            em_in_range_reg <= row_ok && col_ok;
        end
        if (rd_en) begin
            rd_data_reg <= acc_mem[rd_addr];
            rd_vld_reg  <= row_valid_reg[rd_addr];
            rd_idx_reg  <= rd_addr;
        end
        if (wr_en) begin
            acc_mem[wr_idx_reg[FMA_LAT-1]] <= wr_data;
        end
        wr_idx_reg[0] <= rd_idx_reg;
        for (int k = 1; k < FMA_LAT; k++) begin
            wr_idx_reg[k] <= wr_idx_reg[k-1];
        end
        if (hold_load) begin
            hold_reg <= em_res;
        end
        if (out_load) begin
            out_data_reg <= {6'd0, em_col_reg, em_row_reg, hold_reg};
        end
    end

    for (genvar g = 0; g < TILE; g++) begin : g_lane
        assign lane_c[g] = rd_vld_reg ? rd_data_reg[32*g +: 32] : 32'd0;
        assign wr_data[32*g +: 32] = lane_res[g];

        stma_fma u_fma (
            .clk    (clk),
            .a      (a_vec_reg[rd_idx_reg]),
            .b      (b_vec_reg[g]),
            .c      (lane_c[g]),
            .result (lane_res[g])
        );
    end

    stma_fma u_emit_fma (
        .clk    (clk),
        .a      (em_a),
        .b      (em_b),
        .c      (em_c),
        .result (em_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_wr_only_in_update: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_SWEEP || state_reg == ST_DRAIN))
        else $error("accumulator write outside a rank-1 update");

    a_no_out_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || m_tready))
        else $error("pending result word overwritten");

    a_single_read: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({sweep_issue, emit_issue}))
        else $error("two reads of the accumulator memory in one cycle");

    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN && state_next == ST_IDLE) |-> (wr_vld_reg == '0))
        else $error("update left while row writes were pending");

endmodule

// File: src/stma_fma.sv
// Five-stage pipelined IEEE binary32 fused multiply-add, round to nearest even.
`timescale 1ns / 1ps
module stma_fma (
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic [31:0] c,
    output logic [31:0] result
);
    import stma_pkg::*;

    // Stage 1: decode, special cases and the significand product.
    logic              sa, sb, sc, sp;
    logic [7:0]        ea, eb, ec, ea_eff, eb_eff, ec_eff;
    logic [22:0]       fa, fb, fc;
    logic              az, bz, cz, ai, bi, ci, any_nan;
    logic [23:0]       ma, mb, mc;
    logic              spec;
    logic [31:0]       spec_val;

    logic [47:0]        s1_prod_reg;
    logic signed [11:0] s1_ep_reg, s1_ec_reg;
    logic [23:0]        s1_mc_reg;
    logic               s1_sp_reg, s1_sc_reg, s1_cz_reg, s1_spec_reg;
    logic [31:0]        s1_sval_reg;

    always_comb
    begin
        sa = a[31];
        sb = b[31];
        sc = c[31];
        sp = sa ^ sb;
        ea = a[30:23];
        eb = b[30:23];
        ec = c[30:23];
        fa = a[22:0];
        fb = b[22:0];
        fc = c[22:0];
        az = (a[30:0] == 31'd0);
        bz = (b[30:0] == 31'd0);
        cz = (c[30:0] == 31'd0);
        ai = (ea == 8'hFF);
        bi = (eb == 8'hFF);
        ci = (ec == 8'hFF);
        any_nan = (ai && fa != 23'd0) || (bi && fb != 23'd0) || (ci && fc != 23'd0);
        ea_eff = (ea == 8'd0) ? 8'd1 : ea;
        eb_eff = (eb == 8'd0) ? 8'd1 : eb;
        ec_eff = (ec == 8'd0) ? 8'd1 : ec;
        ma = {ea != 8'd0, fa};
        mb = {eb != 8'd0, fb};
        mc = {ec != 8'd0, fc};
        spec     = 1'b1;
        spec_val = FP_QNAN;
        if (any_nan) begin
            spec_val = FP_QNAN;
        end else if (ai || bi) begin
            if (az || bz || (ci && sc != sp)) begin
                spec_val = FP_QNAN;
            end else begin
                spec_val = {sp, FP_INF_MAG};
            end
        end else if (ci) begin
            spec_val = c;
        end else if (az || bz) begin
            if (cz) begin
                spec_val = (sp == sc) ? {sp, 31'd0} : 32'd0;
            end else begin
                spec_val = c;
            end
        end else begin
            spec = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_prod_reg <= ma * mb;
        s1_ep_reg   <= signed'({4'd0, ea_eff}) + signed'({4'd0, eb_eff}) - 12'sd300;
        s1_ec_reg   <= signed'({4'd0, ec_eff}) - 12'sd150;
        s1_mc_reg   <= mc;
        s1_sp_reg   <= sp;
        s1_sc_reg   <= sc;
        s1_cz_reg   <= cz;
        s1_spec_reg <= spec;
        s1_sval_reg <= spec_val;
    end

    // Stage 2: normalize the product and the addend to bit 61.
    logic [6:0]         lz_p, lz_c;
    logic [61:0]        s2_x_reg, s2_y_reg;
    logic signed [11:0] s2_ex_reg, s2_ey_reg;
    logic               s2_sp_reg, s2_sc_reg, s2_cz_reg, s2_spec_reg;
    logic [31:0]        s2_sval_reg;

    assign lz_p = lzc64({s1_prod_reg, 16'd0});
    assign lz_c = lzc64({s1_mc_reg, 40'd0});

    always_ff @(posedge clk)
    begin
        s2_x_reg    <= {s1_prod_reg, 14'd0} << lz_p;
        s2_ex_reg   <= s1_ep_reg - 12'sd14 - signed'({5'd0, lz_p});
        s2_y_reg    <= {s1_mc_reg, 38'd0} << lz_c;
        s2_ey_reg   <= s1_ec_reg - 12'sd38 - signed'({5'd0, lz_c});
        s2_sp_reg   <= s1_sp_reg;
        s2_sc_reg   <= s1_sc_reg;
        s2_cz_reg   <= s1_cz_reg;
        s2_spec_reg <= s1_spec_reg;
        s2_sval_reg <= s1_sval_reg;
    end

    // Stage 3: align the smaller operand with a sticky bit and add.
    logic               x_big;
    logic signed [11:0] diff, shift_d, e_big;
    logic [61:0]        big, small_op, small_sh, small_j;
    logic               s_big, s_small, lost;
    logic [5:0]         d6;
    logic [62:0]        sum;
    logic               sum_sign;

    logic [62:0]        s3_r_reg;
    logic signed [11:0] s3_e_reg;
    logic               s3_sign_reg, s3_spec_reg;
    logic [31:0]        s3_sval_reg;

    always_comb
    begin
        diff     = s2_ex_reg - s2_ey_reg;
        x_big    = (diff >= 12'sd0);
        shift_d  = x_big ? diff : -diff;
        big      = x_big ? s2_x_reg : s2_y_reg;
        small_op = x_big ? s2_y_reg : s2_x_reg;
        s_big    = x_big ? s2_sp_reg : s2_sc_reg;
        s_small  = x_big ? s2_sc_reg : s2_sp_reg;
        e_big    = x_big ? s2_ex_reg : s2_ey_reg;
        d6       = shift_d[5:0];
        small_sh = small_op >> d6;
        lost     = ((small_sh << d6) != small_op);
        small_j  = (shift_d >= 12'sd63) ? 62'd1 : (small_sh | {61'd0, lost});
        sum_sign = s_big;
        if (s2_cz_reg) begin
            sum      = {1'b0, s2_x_reg};
            sum_sign = s2_sp_reg;
            e_big    = s2_ex_reg;
        end else if (s_big == s_small) begin
            sum = {1'b0, big} + {1'b0, small_j};
        end else if (big >= small_j) begin
            sum = {1'b0, big} - {1'b0, small_j};
        end else begin
            sum      = {1'b0, small_j} - {1'b0, big};
            sum_sign = s_small;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_r_reg    <= sum;
        s3_e_reg    <= e_big;
        s3_sign_reg <= sum_sign;
        s3_spec_reg <= s2_spec_reg;
        s3_sval_reg <= s2_sval_reg;
    end

    // Stage 4: normalize the sum and find the rounding position.
    logic [6:0]         lz_r;
    logic signed [11:0] e_lsb, t_sub;
    logic               is_norm;

    logic [62:0]        s4_n_reg;
    logic [6:0]         s4_s_reg;
    logic signed [11:0] s4_base_reg;
    logic               s4_norm_reg, s4_zero_reg, s4_sign_reg, s4_spec_reg;
    logic [31:0]        s4_sval_reg;

    always_comb
    begin
        lz_r    = lzc64({s3_r_reg, 1'b0});
        e_lsb   = s3_e_reg - signed'({5'd0, lz_r});
        t_sub   = -12'sd149 - e_lsb;
        is_norm = (t_sub <= 12'sd39);
    end

    always_ff @(posedge clk)
    begin
        s4_n_reg    <= s3_r_reg << lz_r;
        s4_s_reg    <= is_norm ? 7'd39 : ((t_sub > 12'sd127) ? 7'd127 : t_sub[6:0]);
        s4_base_reg <= e_lsb + 12'sd188;
        s4_norm_reg <= is_norm;
        s4_zero_reg <= (s3_r_reg == 63'd0);
        s4_sign_reg <= s3_sign_reg;
        s4_spec_reg <= s3_spec_reg;
        s4_sval_reg <= s3_sval_reg;
    end

    // Stage 5: shift to the rounding position, round and pack.
    logic [126:0]       shifted;
    logic [24:0]        q, q_rnd;
    logic               guard, sticky, inc, ovf;
    logic signed [11:0] exp_fin;
    logic [30:0]        mag;
    logic [31:0]        res;
    logic [31:0]        result_reg;

    always_comb
    begin
        shifted = {s4_n_reg, 64'd0} >> s4_s_reg;
        q       = shifted[88:64];
        guard   = shifted[63];
        sticky  = |shifted[62:0];
        inc     = guard && (sticky || q[0]);
        q_rnd   = q + {24'd0, inc};
        exp_fin = s4_base_reg + 12'sd1 + signed'({11'd0, q_rnd[24]});
        ovf     = s4_norm_reg && (exp_fin >= 12'sd255);
        mag     = s4_norm_reg ? ({s4_base_reg[7:0], 23'd0} + {6'd0, q_rnd})
                              : {6'd0, q_rnd};
        if (s4_spec_reg) begin
            res = s4_sval_reg;
        end else if (s4_zero_reg) begin
            res = 32'd0;
        end else if (ovf) begin
            res = {s4_sign_reg, FP_INF_MAG};
        end else begin
            res = {s4_sign_reg, mag};
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= res;
    end

    assign result = result_reg;

endmodule

// File: bench/stma_checker.sv
// Checker that predicts and compares the result words of the tile multiply-accumulate block.
`timescale 1ns / 1ps
module stma_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [111:0] s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [47:0]  m_tdata,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_wdata,
    output int           failures,
    output int           waiting
);
    import stma_pkg::*;

    typedef struct packed {
        logic [31:0] c_element;
        logic [4:0]  out_row;
        logic [4:0]  out_col;
    } tile_result_t;

    logic [31:0]  acc_tile [1024];
    logic [31:0]  a_lanes [32];
    logic [31:0]  b_lanes [32];
    logic [31:0]  alpha_reg;
    logic [31:0]  beta_reg;
    tile_result_t result_q [$];

    function automatic int msb_pos(logic [63:0] v);
        for (int k = 63; k >= 0; k--)
            if (v[k]) return k;
        return 0;
    endfunction

    function automatic logic [31:0] pack_round(logic s, logic [63:0] r, int e);
        int          p;
        int          sh;
        int          biased;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        p  = msb_pos(r);
        sh = p - 23;
        if (-149 - e > sh) sh = -149 - e;
        if (sh <= 0) begin
            q = r << (-sh);
        end
        else if (sh >= 64) begin
            return {s, 31'd0};
        end
        else begin
            rem  = r & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            q    = r >> sh;
            if (rem > half || (rem == half && q[0])) q = q + 64'd1;
            if (q == (64'd1 << 24)) begin
                q  = q >> 1;
                sh = sh + 1;
            end
        end
        if (q >= 64'h80_0000) begin
            biased = e + sh + 150;
            if (biased >= 255) return {s, 8'hFF, 23'd0};
            return {s, biased[7:0], q[22:0]};
        end
        return {s, 8'd0, q[22:0]};
    endfunction

    function automatic logic [31:0] fused_mul_add(logic [31:0] a, logic [31:0] b,
                                                 logic [31:0] c);
        logic        sp;
        logic        s_hi;
        logic        s_lo;
        int          ea;
        int          eb;
        int          ec;
        int          ep;
        int          e_c;
        int          ex;
        int          ey;
        int          d;
        logic        az;
        logic        bz;
        logic        cz;
        logic        ai;
        logic        bi;
        logic        ci;
        logic [63:0] mp;
        logic [63:0] mc;
        logic [63:0] xm;
        logic [63:0] ym;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] r;
        sp = a[31] ^ b[31];
        ea = a[30:23];
        eb = b[30:23];
        ec = c[30:23];
        az = a[30:0] == 0;
        bz = b[30:0] == 0;
        cz = c[30:0] == 0;
        ai = ea == 255;
        bi = eb == 255;
        ci = ec == 255;
        if ((ai && a[22:0] != 0) || (bi && b[22:0] != 0) || (ci && c[22:0] != 0))
            return FP_QNAN;
        if (ai || bi) begin
            if (az || bz) return FP_QNAN;
            if (ci && c[31] != sp) return FP_QNAN;
            return {sp, FP_INF_MAG};
        end
        if (ci) return c;
        if (az || bz) begin
            if (cz) return (sp == c[31]) ? {sp, 31'd0} : 32'd0;
            return c;
        end
        mp = {40'd0, (ea != 0), a[22:0]} * {40'd0, (eb != 0), b[22:0]};
        ep = (ea != 0 ? ea : 1) + (eb != 0 ? eb : 1) - 300;
        if (cz) return pack_round(sp, mp, ep);
        mc  = {40'd0, (ec != 0), c[22:0]};
        e_c = (ec != 0 ? ec : 1) - 150;
        xm  = mp << (61 - msb_pos(mp));
        ex  = ep - (61 - msb_pos(mp));
        ym  = mc << (61 - msb_pos(mc));
        ey  = e_c - (61 - msb_pos(mc));
        if (ex >= ey) begin
            hi = xm; s_hi = sp; lo = ym; s_lo = c[31]; d = ex - ey;
        end
        else begin
            hi = ym; s_hi = c[31]; lo = xm; s_lo = sp; d = ey - ex; ex = ey;
        end
        if (d >= 63) lo = 64'd1;
        else lo = (lo >> d) | 64'(((lo & ((64'd1 << d) - 64'd1)) != 0));
        if (s_hi == s_lo) begin
            r = hi + lo;
        end
        else if (hi >= lo) begin
            r = hi - lo;
        end
        else begin
            r    = lo - hi;
            s_hi = s_lo;
        end
        if (r == 0) return 32'd0;
        return pack_round(s_hi, r, ex);
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        logic [4:0]   r;
        logic [4:0]   c;
        logic [31:0]  z;
        logic [31:0]  t;
        tile_result_t got;
        tile_result_t want;
        if (!rst_n) begin
            for (int k = 0; k < 1024; k++) acc_tile[k] = 32'd0;
            for (int k = 0; k < 32; k++) a_lanes[k] = 32'd0;
            for (int k = 0; k < 32; k++) b_lanes[k] = 32'd0;
            alpha_reg = FP_ONE;
            beta_reg  = 32'd0;
            result_q.delete();
            failures  = 0;
            waiting   = 0;
        end
        else begin
            if (cfg_we) begin
                if (cfg_index == REG_ALPHA) alpha_reg = cfg_wdata;
                else if (cfg_index == REG_BETA) beta_reg = cfg_wdata;
            end
            if (m_tvalid && m_tready) begin
                got = {m_tdata[31:0], m_tdata[36:32], m_tdata[41:37]};
                if (result_q.size() == 0) begin
                    $error("unexpected result word: c_element %h", got.c_element);
                    failures++;
                end
                else begin
                    want = result_q.pop_front();
                    if (got.c_element !== want.c_element) begin
                        $error("c_element expected %h actual %h", want.c_element, got.c_element);
                        failures++;
                    end
                    if (got.out_row !== want.out_row) begin
                        $error("out_row expected %0d actual %0d", want.out_row, got.out_row);
                        failures++;
                    end
                    if (got.out_col !== want.out_col) begin
                        $error("out_col expected %0d actual %0d", want.out_col, got.out_col);
                        failures++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                r = s_tdata[4:0];
                c = s_tdata[9:5];
                case (cmd_t'(s_tuser))
                    CMD_CLEAR:
                        for (int k = 0; k < 1024; k++) acc_tile[k] = 32'd0;
                    CMD_LOAD: begin
                        a_lanes[r] = s_tdata[41:10];
                        b_lanes[c] = s_tdata[73:42];
                    end
                    CMD_UPDATE:
                        for (int i = 0; i < 32; i++)
                            for (int j = 0; j < 32; j++)
                                acc_tile[i * 32 + j] =
                                    fused_mul_add(a_lanes[i], b_lanes[j], acc_tile[i * 32 + j]);
                    default: begin
                        z = acc_tile[{r, c}];
                        t = fused_mul_add(alpha_reg, z, FP_NEG_ZERO);
                        if (beta_reg[30:0] != 0) t = fused_mul_add(s_tdata[105:74], beta_reg, t);
                        result_q.push_back({t, r, c});
                    end
                endcase
            end
            waiting = result_q.size();
        end
    end

endmodule

// File: bench/sgemm_tile_multiply_accumulate_tb.sv
// Top of the testbench: clock, reset, stimulus, register settings and the verdict.
`timescale 1ns / 1ps
module sgemm_tile_multiply_accumulate_tb;
    import stma_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int SETTLE     = 60;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [111:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [47:0]  m_tdata;
    logic         cfg_we;
    logic         cfg_index;
    logic [31:0]  cfg_wdata;
    int           failures;
    int           waiting;
    logic         calm;
    int           stall_left;
    int           idle_cycles;

    sgemm_tile_multiply_accumulate u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    stma_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .failures  (failures),
        .waiting   (waiting)
    );

    always #2 clk = ~clk;

    always @(posedge clk) begin
        if (calm) begin
            m_tready <= 1'b1;
        end
        else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(0, 2);
            m_tready <= 1'b0;
        end
        else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("sgemm_tile_multiply_accumulate verification failed");
            $finish;
        end
    end

    function automatic logic [31:0] pick_float();
        logic s;
        s = $urandom_range(0, 1);
        case ($urandom_range(0, 19))
            0:       return {s, 31'd0};
            1:       return {s, 8'hFF, 23'd0};
            2:       return {s, 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
            3:       return {s, 8'd0, 23'($urandom())};
            4:       return $urandom();
            5:       return {s, 8'hFE, 23'h7F_FFFF};
            default: return {s, 8'($urandom_range(118, 136)), 23'($urandom())};
        endcase
    endfunction

    task automatic send_word(cmd_t cmd, logic [4:0] r, logic [4:0] c,
                             logic [31:0] a, logic [31:0] b, logic [31:0] oc);
        int gap;
        gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'd0, oc, b, a, c, r};
        do @(posedge clk); while (!s_tready);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge clk);
        while (waiting != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_scales(logic [31:0] alpha, logic [31:0] beta);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ALPHA;
        cfg_wdata <= alpha;
        @(posedge clk);
        cfg_index <= REG_BETA;
        cfg_wdata <= beta;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_mix(int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
                send_word(CMD_CLEAR, 5'($urandom()), 5'($urandom()), $urandom(), $urandom(),
                          $urandom());
            else if (pick < 38)
                send_word(CMD_LOAD, 5'($urandom()), 5'($urandom()), pick_float(),
                          pick_float(), $urandom());
            else if (pick < 55)
                send_word(CMD_UPDATE, 5'($urandom()), 5'($urandom()), $urandom(),
                          $urandom(), $urandom());
            else
                send_word(CMD_EMIT, 5'($urandom()), 5'($urandom()), $urandom(), $urandom(),
                          pick_float());
        end
    endtask

    initial begin
        logic [31:0] edge_vals [8];
        clk        = 1'b0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = CMD_CLEAR;
        m_tready   = 1'b1;
        cfg_we     = 1'b0;
        cfg_index  = REG_ALPHA;
        cfg_wdata  = '0;
        calm       = 1'b0;
        stall_left = 0;
        idle_cycles = 0;
        edge_vals  = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                       32'h0000_0001, 32'h7F7F_FFFF, 32'hFFFF_FFFF, 32'h3F80_0000};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset state: accumulators read as zero before anything is loaded.
        send_word(CMD_EMIT, 5'd0, 5'd31, 32'd0, 32'd0, 32'hFFFF_FFFF);
        for (int k = 0; k < 32; k++)
            send_word(CMD_LOAD, 5'(k), 5'(31 - k), (k < 8) ? edge_vals[k] : pick_float(),
                      (k >= 24) ? edge_vals[k - 24] : pick_float(), 32'd0);
        send_word(CMD_UPDATE, 5'd0, 5'd0, 32'd0, 32'd0, 32'd0);
        send_word(CMD_EMIT, 5'd0, 5'd0, 32'd0, 32'd0, 32'd0);
        send_word(CMD_EMIT, 5'd31, 5'd31, 32'd0, 32'd0, 32'h7FC0_0000);
        send_word(CMD_EMIT, 5'd2, 5'd30, 32'd0, 32'd0, 32'd0);
        send_word(CMD_EMIT, 5'd9, 5'd3, 32'd0, 32'd0, 32'd0);
        send_word(CMD_CLEAR, 5'd31, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_EMIT, 5'd31, 5'd0, 32'd0, 32'd0, 32'h3F80_0000);
        settle();
        write_scales(32'h4000_0000, 32'h8000_0000);
        send_word(CMD_EMIT, 5'd4, 5'd4, 32'd0, 32'd0, 32'h7F80_0000);
        settle();

        write_scales(32'h3F80_0000, 32'h3F00_0000);
        random_mix(210);
        settle();
        write_scales(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_mix(200);
        settle();
        write_scales(32'h0000_0000, 32'h7F7F_FFFF);
        random_mix(200);
        settle();
        write_scales(pick_float(), pick_float());
        random_mix(200);
        settle();
        write_scales(32'hBF80_0000, 32'h0000_0001);
        calm = 1'b1;
        random_mix(200);
        settle();

        if (failures == 0)
            $display("sgemm_tile_multiply_accumulate verification clean");
        else
            $display("sgemm_tile_multiply_accumulate verification failed");
        $finish;
    end

endmodule
